@@ sv/mppt_perturb_observe_with_sweep_defines.svh @@
// Assertion macros for the MPPT perturb-and-observe block.
// Used by the top level; expects i_clk and i_rst_n in scope.
`ifndef MPPT_PERTURB_OBSERVE_WITH_SWEEP_DEFINES_SVH
`define MPPT_PERTURB_OBSERVE_WITH_SWEEP_DEFINES_SVH

// same-cycle implication
`define MPPT_POS_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define MPPT_POS_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ sv/mppt_pos_pkg.sv @@
// Shared constants, register codes and types of the MPPT tracker.
// No dependencies.
package mppt_pos_pkg;

    localparam int ADC_BITS = 10;
    localparam int POWER_W  = 20;
    localparam int PROD_W   = 2 * ADC_BITS;
    localparam int EXT_W    = (PROD_W > POWER_W) ? PROD_W : POWER_W;
    localparam int DUTY_W   = 8;
    localparam int CFG_W    = 8;
    localparam int CFG_IDX_W = 3;

    // voltage compare: raw*1000/1012 against limit is raw*250 against limit*253
    localparam int VOLT_NUM = 250;
    localparam int VOLT_DEN = 253;
    localparam int VS_W     = ADC_BITS + 8;
    localparam int THR_W    = 18;
    localparam int VCMP_W   = (VS_W > THR_W) ? VS_W : THR_W;

    localparam int CUR_W    = ADC_BITS - 2;
    localparam int CURC_W   = (CUR_W > CFG_W) ? CUR_W : CFG_W;

    // charge limit (LIM_BASE - LIM_SLOPE*t) / 5
    localparam int T_LOW      = -29;
    localparam int T_HIGH     = 49;
    localparam int T_DEFAULT  = 25;
    localparam int LIM_BASE   = 3525;
    localparam int LIM_SLOPE  = 3;
    localparam int RECIP5     = 52429;
    localparam int RECIP5_SH  = 18;

    localparam logic [CFG_IDX_W-1:0] CFG_AIR_TEMP    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_CURRENT_LIM = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_DUTY_MIN    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_DUTY_MAX    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_SWEEP_STEP  = 3'd4;

    localparam logic [CFG_W-1:0] RST_AIR_TEMP    = 8'd20;
    localparam logic [CFG_W-1:0] RST_CURRENT_LIM = 8'd200;
    localparam logic [CFG_W-1:0] RST_DUTY_MIN    = 8'd30;
    localparam logic [CFG_W-1:0] RST_DUTY_MAX    = 8'd200;
    localparam logic [CFG_W-1:0] RST_SWEEP_STEP  = 8'd5;

    typedef struct packed {
        logic [CFG_W-1:0] air_temperature;
        logic [CFG_W-1:0] current_limit;
        logic [CFG_W-1:0] duty_min;
        logic [CFG_W-1:0] duty_max;
        logic [CFG_W-1:0] sweep_step;
    } t_cfg;

    typedef struct packed {
        logic [VCMP_W-1:0] thr_lo;
        logic [VCMP_W-1:0] thr_hi;
    } t_lim;

    typedef struct packed {
        logic [EXT_W-1:0]  power;
        logic [VCMP_W-1:0] volt_scaled;
        logic [CURC_W-1:0] current;
    } t_meas;

endpackage

@@ sv/mppt_pos_ifs.sv @@
// Valid/ready channel interfaces: sample input, result output, register write.
// Depends on mppt_pos_pkg.
interface mppt_pos_in_if;
    logic                               valid;
    logic                               ready;
    logic [mppt_pos_pkg::ADC_BITS-1:0]  battery_sample;
    logic [mppt_pos_pkg::ADC_BITS-1:0]  shunt_sample;
    modport source (output valid, battery_sample, shunt_sample, input ready);
    modport sink (input valid, battery_sample, shunt_sample, output ready);
endinterface

interface mppt_pos_out_if;
    logic                               valid;
    logic                               ready;
    logic [mppt_pos_pkg::DUTY_W-1:0]    duty_out;
    logic                               sweeping;
    logic [mppt_pos_pkg::POWER_W-1:0]   power_value;
    modport source (output valid, duty_out, sweeping, power_value, input ready);
    modport sink (input valid, duty_out, sweeping, power_value, output ready);
endinterface

interface mppt_pos_cfg_if;
    logic                               valid;
    logic                               ready;
    logic [mppt_pos_pkg::CFG_IDX_W-1:0] index;
    logic [mppt_pos_pkg::CFG_W-1:0]     data;
    modport source (output valid, index, data, input ready);
    modport sink (input valid, index, data, output ready);
endinterface

@@ sv/mppt_pos_lim.sv @@
// Charge voltage limit thresholds, registered from the temperature setting.
// Depends on mppt_pos_pkg.
module mppt_pos_lim (
    input  logic                 i_clk,
    input  mppt_pos_pkg::t_cfg   i_cfg,
    output mppt_pos_pkg::t_lim   o_lim
);

    localparam int N_W = 12;
    localparam int Q_W = 10;
    localparam int P_W = 28;

    logic signed [mppt_pos_pkg::CFG_W-1:0] temp;
    logic signed [mppt_pos_pkg::CFG_W-1:0] temp_used;
    logic [N_W-1:0]                        lim_num;
    logic [P_W-1:0]                        lim_prod;
    logic [Q_W-1:0]                        lim_q;
    mppt_pos_pkg::t_lim                    n_lim;
    mppt_pos_pkg::t_lim                    r_lim;

    always_comb begin
        temp = $signed(i_cfg.air_temperature);
        if (temp >= mppt_pos_pkg::CFG_W'(mppt_pos_pkg::T_LOW)
                && temp <= mppt_pos_pkg::CFG_W'(mppt_pos_pkg::T_HIGH)) begin
            temp_used = temp;
        end else begin
            temp_used = mppt_pos_pkg::CFG_W'(mppt_pos_pkg::T_DEFAULT);
        end
        lim_num  = N_W'(mppt_pos_pkg::LIM_BASE - mppt_pos_pkg::LIM_SLOPE * int'(temp_used));
        lim_prod = P_W'(lim_num) * P_W'(mppt_pos_pkg::RECIP5);
        lim_q    = Q_W'(lim_prod >> mppt_pos_pkg::RECIP5_SH);
        n_lim.thr_lo = mppt_pos_pkg::VCMP_W'(lim_q)
                       * mppt_pos_pkg::VCMP_W'(mppt_pos_pkg::VOLT_DEN);
        n_lim.thr_hi = n_lim.thr_lo + mppt_pos_pkg::VCMP_W'(mppt_pos_pkg::VOLT_DEN);
    end

    always_ff @(posedge i_clk) begin
        r_lim <= n_lim;
    end

    assign o_lim = r_lim;

endmodule

@@ sv/mppt_pos_meas.sv @@
// Input stage: accept a sample beat, register power, scaled voltage and current.
// Depends on mppt_pos_pkg and mppt_pos_ifs.
module mppt_pos_meas (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    mppt_pos_in_if.sink          i_in,
    input  logic                 i_adv,
    output logic                 o_valid,
    output mppt_pos_pkg::t_meas  o_meas
);

    logic                 r_valid;
    mppt_pos_pkg::t_meas  r_meas;
    mppt_pos_pkg::t_meas  n_meas;
    logic                 accept;

    assign i_in.ready = !r_valid || i_adv;
    assign accept     = i_in.valid && i_in.ready;

    always_comb begin
        n_meas.power = mppt_pos_pkg::EXT_W'(i_in.battery_sample)
                       * mppt_pos_pkg::EXT_W'(i_in.shunt_sample);
        n_meas.volt_scaled = mppt_pos_pkg::VCMP_W'(i_in.battery_sample)
                             * mppt_pos_pkg::VCMP_W'(mppt_pos_pkg::VOLT_NUM);
        n_meas.current = mppt_pos_pkg::CURC_W'(i_in.shunt_sample >> 2);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (accept) begin
            r_valid <= 1'b1;
        end else if (i_adv) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_meas <= n_meas;
        end
    end

    assign o_valid = r_valid;
    assign o_meas  = r_meas;

endmodule

@@ sv/mppt_pos_core.sv @@
// Tracker state update (perturb-and-observe and sweep) and result register.
// Depends on mppt_pos_pkg and mppt_pos_ifs.
module mppt_pos_core (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    input  mppt_pos_pkg::t_meas  i_meas,
    input  mppt_pos_pkg::t_cfg   i_cfg,
    input  mppt_pos_pkg::t_lim   i_lim,
    output logic                 o_adv,
    mppt_pos_out_if.source       o_out
);

    localparam int DW = mppt_pos_pkg::DUTY_W;
    localparam int PW = mppt_pos_pkg::EXT_W;

    logic [DW-1:0]  r_duty, n_duty;
    logic           r_dir, n_dir;
    logic [PW-1:0]  r_prev, n_prev;
    logic           r_sweep, n_sweep;
    logic [PW-1:0]  r_best_p, n_best_p;
    logic [DW-1:0]  r_best_d, n_best_d;

    logic                              r_out_valid;
    logic [DW-1:0]                     r_duty_out;
    logic                              r_sweeping;
    logic [mppt_pos_pkg::POWER_W-1:0]  r_power;

    logic [DW-1:0]                     step;
    logic [DW:0]                       next_pt;
    logic [mppt_pos_pkg::CURC_W-1:0]   cur_lim;
    logic                              over;
    logic                              below;
    logic                              finish;

    assign o_adv = i_valid && (!r_out_valid || o_out.ready);

    always_comb begin
        n_duty   = r_duty;
        n_dir    = r_dir;
        n_prev   = r_prev;
        n_sweep  = r_sweep;
        n_best_p = r_best_p;
        n_best_d = r_best_d;
        finish   = 1'b0;
        step     = (i_cfg.sweep_step == '0) ? DW'(1) : i_cfg.sweep_step;
        next_pt  = {1'b0, r_duty} + {1'b0, step};
        cur_lim  = mppt_pos_pkg::CURC_W'(i_cfg.current_limit);
        over     = (i_meas.volt_scaled >= i_lim.thr_hi) || (i_meas.current > cur_lim);
        below    = (i_meas.volt_scaled < i_lim.thr_lo) && (i_meas.current < cur_lim);
        if (r_sweep) begin
            finish = over;
            if (!over) begin
                if (i_meas.power > r_best_p) begin
                    n_best_p = i_meas.power;
                    n_best_d = r_duty;
                end
                if (next_pt > {1'b0, i_cfg.duty_max}) begin
                    finish = 1'b1;
                end else begin
                    n_duty = next_pt[DW-1:0];
                end
            end
            if (finish) begin
                n_duty  = n_best_d;
                n_sweep = 1'b0;
            end
        end else if (r_duty > i_cfg.duty_min && r_duty < i_cfg.duty_max) begin
            if (i_meas.power < r_prev) begin
                n_dir = !r_dir;
            end
            if (n_dir && below) begin
                n_duty = r_duty + DW'(1);
            end else begin
                n_duty = r_duty - DW'(1);
            end
            n_prev = i_meas.power;
        end else begin
            n_best_p = '0;
            n_best_d = '0;
            if (i_cfg.duty_min <= i_cfg.duty_max) begin
                n_duty  = i_cfg.duty_min;
                n_sweep = 1'b1;
            end else begin
                n_duty = '0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_duty      <= '0;
            r_dir       <= 1'b1;
            r_prev      <= '0;
            r_sweep     <= 1'b0;
            r_best_p    <= '0;
            r_best_d    <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (o_adv) begin
                r_duty      <= n_duty;
                r_dir       <= n_dir;
                r_prev      <= n_prev;
                r_sweep     <= n_sweep;
                r_best_p    <= n_best_p;
                r_best_d    <= n_best_d;
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_adv) begin
            r_duty_out <= n_duty;
            r_sweeping <= n_sweep;
            r_power    <= i_meas.power[mppt_pos_pkg::POWER_W-1:0];
        end
    end

    assign o_out.valid       = r_out_valid;
    assign o_out.duty_out    = r_duty_out;
    assign o_out.sweeping    = r_sweeping;
    assign o_out.power_value = r_power;

endmodule

@@ sv/mppt_perturb_observe_with_sweep.sv @@
// MPPT tracker top level: config registers, input stage, limits, tracker core.
// An accepted sample beat is registered in the input stage, then in the result
// register. Throughput: one beat per cycle while the output is not stalled; the
// input stage and the result register pass on together, so a stalled output holds
// at most two beats in flight. Reset (synchronous, active low) loads the register
// defaults and the tracker state; thresholds follow the registers in the cycle after.
`include "mppt_perturb_observe_with_sweep_defines.svh"

module mppt_perturb_observe_with_sweep (
    input  logic            i_clk,
    input  logic            i_rst_n,
    mppt_pos_in_if.sink     i_in,
    mppt_pos_cfg_if.sink    i_cfg,
    mppt_pos_out_if.source  o_out
);

    mppt_pos_pkg::t_cfg   r_cfg;
    mppt_pos_pkg::t_lim   lim;
    mppt_pos_pkg::t_meas  meas;
    logic                 s1_valid;
    logic                 s2_adv;

    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.air_temperature <= mppt_pos_pkg::RST_AIR_TEMP;
            r_cfg.current_limit   <= mppt_pos_pkg::RST_CURRENT_LIM;
            r_cfg.duty_min        <= mppt_pos_pkg::RST_DUTY_MIN;
            r_cfg.duty_max        <= mppt_pos_pkg::RST_DUTY_MAX;
            r_cfg.sweep_step      <= mppt_pos_pkg::RST_SWEEP_STEP;
        end else if (i_cfg.valid && i_cfg.ready) begin
            unique case (i_cfg.index)
                mppt_pos_pkg::CFG_AIR_TEMP:    r_cfg.air_temperature <= i_cfg.data;
                mppt_pos_pkg::CFG_CURRENT_LIM: r_cfg.current_limit   <= i_cfg.data;
                mppt_pos_pkg::CFG_DUTY_MIN:    r_cfg.duty_min        <= i_cfg.data;
                mppt_pos_pkg::CFG_DUTY_MAX:    r_cfg.duty_max        <= i_cfg.data;
                mppt_pos_pkg::CFG_SWEEP_STEP:  r_cfg.sweep_step      <= i_cfg.data;
                default: begin
                end
            endcase
        end
    end

    mppt_pos_lim u_lim (
        .i_clk (i_clk),
        .i_cfg (r_cfg),
        .o_lim (lim)
    );

    mppt_pos_meas u_meas (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (i_in),
        .i_adv   (s2_adv),
        .o_valid (s1_valid),
        .o_meas  (meas)
    );

    mppt_pos_core u_core (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (s1_valid),
        .i_meas  (meas),
        .i_cfg   (r_cfg),
        .i_lim   (lim),
        .o_adv   (s2_adv),
        .o_out   (o_out)
    );

    `MPPT_POS_ASSERT_IMP(a_stall_blocks_input, s1_valid && !s2_adv, !i_in.ready, "input taken while stage full")
    `MPPT_POS_ASSERT_NXT(a_adv_gives_result, s2_adv, o_out.valid, "advanced beat produced no result")
    `MPPT_POS_ASSERT_NXT(a_no_extra_result, o_out.valid && o_out.ready && !s2_adv, !o_out.valid, "result beat repeated")

endmodule
